// File: rtl/core/isoct_pkg.sv
package isoct_pkg;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam int FRAME_W = 20;
    localparam int BIT_W   = 4;
    localparam int WAIT_W  = 32;

    localparam logic [15:0] ETU_RESET     = 16'd1664;
    localparam logic [7:0]  OFFSET_RESET  = 8'd10;
    localparam logic [31:0] TIMEOUT_RESET = 32'd0;
    localparam logic        DISCARD_RESET = 1'b1;

    localparam logic [BIT_W-1:0] LAST_DATA_BIT = 4'd8;
    localparam logic [BIT_W-1:0] PARITY_SLOT   = 4'd9;
    localparam logic [BIT_W-1:0] LAST_TX_BIT   = 4'd11;
    localparam logic [7:0]       FALSE_CHAR    = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SEND = 2'd1,
        OP_ARM  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ETU     = 2'd0,
        CFG_OFFSET  = 2'd1,
        CFG_TIMEOUT = 2'd2,
        CFG_DISCARD = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       line_in;
    } item_t;

    // packed MSB first, so line_out lands in bit 0
    typedef struct packed {
        logic       busy_res;
        logic       rx_timeout;
        logic       rx_parity_ok;
        logic       rx_check_bit;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       line_out;
    } res_t;

    typedef struct packed {
        logic [15:0] etu;       // already forced to at least 1
        logic [7:0]  offset;
        logic [31:0] timeout;
        logic        discard;
    } cfg_t;

endpackage

// File: rtl/core/iso7816_char_transceiver_core.sv
// Channel   | Ports          | Contents
// ----------+----------------+----------------------------------------------------
// tick in   | s_tvalid/tready| tdata: tx_byte[7:0], line_in[8]; tuser: op[1:0]
// result out| m_tvalid/tready| tdata: line_out, rx_valid, rx_byte, check, ok, ...
// config    | cfg_wr_en      | cfg_index selects register, cfg_wdata holds value
//
// One beat per clock unless results stall; results go via the tick and result registers.
// The tick register feeds the frame engine, which updates its state and the
// result register in the same cycle; each frame compare is one 20-bit equality.
// Reset (aresetn low, synchronous) idles the engine and loads register defaults.
// A stalled result holds; the input stage still takes one more beat, then stalls.
module iso7816_char_transceiver_core
    import isoct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] tx_byte, [8] line_in, rest zero
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] line_out, [1] rx_valid, [9:2] rx_byte,
                                            // [10] rx_check_bit, [11] rx_parity_ok,
                                            // [12] rx_timeout, [13] busy_res
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    logic [15:0] etu_reg;
    logic [7:0]  offset_reg;
    logic [31:0] timeout_reg;
    logic        discard_reg;
    cfg_t        cfg;

    logic  in_vld;
    item_t item;
    res_t  res;
    logic  out_ready;
    logic  adv;

    assign adv         = in_vld && out_ready;
    assign cfg.etu     = (etu_reg == '0) ? 16'd1 : etu_reg;
    assign cfg.offset  = offset_reg;
    assign cfg.timeout = timeout_reg;
    assign cfg.discard = discard_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            etu_reg     <= ETU_RESET;
            offset_reg  <= OFFSET_RESET;
            timeout_reg <= TIMEOUT_RESET;
            discard_reg <= DISCARD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ETU:     etu_reg     <= cfg_wdata[15:0];
                CFG_OFFSET:  offset_reg  <= cfg_wdata[7:0];
                CFG_TIMEOUT: timeout_reg <= cfg_wdata[31:0];
                CFG_DISCARD: discard_reg <= cfg_wdata[0];
                default:     etu_reg     <= etu_reg;
            endcase
        end
    end

    isoct_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .adv      (adv),
        .vld      (in_vld),
        .item     (item)
    );

    isoct_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .item    (item),
        .cfg     (cfg),
        .res     (res)
    );

    isoct_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (adv),
        .res      (res),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/core/isoct_in_stage.sv
module isoct_in_stage
    import isoct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 adv,
    output logic                 vld,
    output item_t                item
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    logic  load;

    assign s_tready = !vld_reg || adv;
    assign load     = s_tvalid && s_tready;
    assign vld_next = load || (vld_reg && !adv);
    assign vld      = vld_reg;
    assign item     = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.op      <= s_tuser;
            item_reg.tx_byte <= s_tdata[7:0];
            item_reg.line_in <= s_tdata[8];
        end
    end

endmodule

// File: rtl/core/isoct_engine.sv
module isoct_engine
    import isoct_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    mode_t              mode_reg, mode_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [FRAME_W-1:0] target_reg, target_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic               parity_reg, parity_next;
    logic               armed_reg, armed_next;
    logic               first_reg, first_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;

    logic [FRAME_W-1:0] etu20;
    logic [FRAME_W-1:0] frame_inc;
    logic [WAIT_W-1:0]  wait_base;
    logic [WAIT_W-1:0]  wait_inc;
    logic [BIT_W-1:0]   tx_sel;
    logic               armed_now;
    logic               drop;

    assign etu20     = {{(FRAME_W-16){1'b0}}, cfg.etu};
    assign frame_inc = frame_reg + {{(FRAME_W-1){1'b0}}, 1'b1};
    assign tx_sel    = bit_reg - {{(BIT_W-1){1'b0}}, 1'b1};
    assign wait_base = (item.op == OP_ARM) ? '0 : wait_reg;
    assign wait_inc  = (&wait_base) ? wait_base : wait_base + {{(WAIT_W-1){1'b0}}, 1'b1};
    assign armed_now = armed_reg || (item.op == OP_ARM);
    assign drop      = cfg.discard && first_reg && (shift_reg == FALSE_CHAR) && parity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            frame_reg  <= '0;
            target_reg <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            parity_reg <= 1'b0;
            armed_reg  <= 1'b0;
            first_reg  <= 1'b0;
            wait_reg   <= '0;
        end else if (adv) begin
            mode_reg   <= mode_next;
            frame_reg  <= frame_next;
            target_reg <= target_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            parity_reg <= parity_next;
            armed_reg  <= armed_next;
            first_reg  <= first_next;
            wait_reg   <= wait_next;
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        frame_next  = frame_reg;
        target_next = target_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        parity_next = parity_reg;
        armed_next  = armed_reg;
        first_next  = first_reg;
        wait_next   = wait_reg;
        res          = '0;
        res.line_out = 1'b1;

        unique case (mode_reg)
            MODE_IDLE: begin
                if (item.op == OP_SEND) begin
                    // first tick of the frame already drives the start bit
                    res.busy_res = 1'b1;
                    res.line_out = 1'b0;
                    mode_next    = MODE_TX;
                    shift_next   = item.tx_byte;
                    parity_next  = ^item.tx_byte;
                    frame_next   = {{(FRAME_W-1){1'b0}}, 1'b1};
                    bit_next     = '0;
                    target_next  = etu20;
                    if (etu20 == {{(FRAME_W-1){1'b0}}, 1'b1}) begin
                        bit_next    = {{(BIT_W-1){1'b0}}, 1'b1};
                        target_next = etu20 + etu20;
                    end
                end else begin
                    if (item.op == OP_ARM) begin
                        armed_next = 1'b1;
                        wait_next  = '0;
                        first_next = 1'b1;
                    end
                    if (armed_now) begin
                        if (!item.line_in) begin
                            // start edge: this tick is frame tick 0
                            res.busy_res = 1'b1;
                            mode_next    = MODE_RX;
                            frame_next   = '0;
                            bit_next     = '0;
                            shift_next   = '0;
                            parity_next  = 1'b0;
                            target_next  = {{(FRAME_W-8){1'b0}}, cfg.offset} + etu20;
                        end else begin
                            wait_next = wait_inc;
                            if ((cfg.timeout != '0) && (wait_inc > cfg.timeout)) begin
                                res.rx_timeout = 1'b1;
                                armed_next     = 1'b0;
                            end
                        end
                    end
                end
            end
            MODE_TX: begin
                res.busy_res = 1'b1;
                if (bit_reg == '0) begin
                    res.line_out = 1'b0;
                end else if (bit_reg <= LAST_DATA_BIT) begin
                    res.line_out = shift_reg[tx_sel[2:0]];
                end else if (bit_reg == PARITY_SLOT) begin
                    res.line_out = parity_reg;
                end else begin
                    res.line_out = 1'b1;
                end
                frame_next = frame_inc;
                if (frame_inc == target_reg) begin
                    if (bit_reg == LAST_TX_BIT) begin
                        mode_next  = MODE_IDLE;
                        bit_next   = '0;
                        frame_next = '0;
                    end else begin
                        bit_next    = bit_reg + {{(BIT_W-1){1'b0}}, 1'b1};
                        target_next = target_reg + etu20;
                    end
                end
            end
            MODE_RX: begin
                res.busy_res = 1'b1;
                frame_next   = frame_inc;
                if (frame_inc == target_reg) begin
                    if (bit_reg < LAST_DATA_BIT) begin
                        shift_next[bit_reg[2:0]] = item.line_in;
                        bit_next    = bit_reg + {{(BIT_W-1){1'b0}}, 1'b1};
                        target_next = target_reg + etu20;
                    end else if (bit_reg == LAST_DATA_BIT) begin
                        // check bit; the frame closes two ETU later
                        parity_next = item.line_in;
                        bit_next    = PARITY_SLOT;
                        target_next = target_reg + etu20 + etu20;
                    end else begin
                        if (!drop) begin
                            res.rx_valid     = 1'b1;
                            res.rx_byte      = shift_reg;
                            res.rx_check_bit = parity_reg;
                            res.rx_parity_ok = (parity_reg == ^shift_reg);
                            first_next       = 1'b0;
                        end
                        mode_next  = MODE_IDLE;
                        bit_next   = '0;
                        frame_next = '0;
                    end
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/isoct_out_stage.sv
module isoct_out_stage
    import isoct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  res_t                 res,
    output logic                 ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic vld_reg;
    logic vld_next;
    res_t res_reg;

    assign ready    = !vld_reg || m_tready;
    assign vld_next = load || (vld_reg && !m_tready);
    assign m_tvalid = vld_reg;
    assign m_tdata  = {{(M_TDATA_W-$bits(res_t)){1'b0}}, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/core/isoct_checker.sv
module isoct_checker
    import isoct_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input side backs up only when the result side is stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

    a_rx_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[13] && !m_tdata[12])
        else $error("character reported outside a frame or with timeout");

    a_rx_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[11:2] == '0)
        else $error("receive fields set without a character");

endmodule

bind iso7816_char_transceiver_core isoct_checker u_isoct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/iso7816_char_transceiver_core_tb.sv
`timescale 1ns / 1ps
module iso7816_char_transceiver_core_tb;
    import isoct_pkg::*;

    localparam int unsigned REPORT_ETU = 11;    // receive report point, in ETU after the edge
    localparam int unsigned FRAME_ETUS = 12;    // start, 8 data, check, 2 guard
    localparam int unsigned LONG_HOLD  = 400;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;  // undefined op code, behaves as a plain tick

    // Tracks the frame engine tick by tick and holds the results still to come.
    class char_frame_checker;
        logic [15:0]        etu_reg;
        logic [7:0]         offset_reg;
        logic [31:0]        timeout_reg;
        logic               discard_reg;
        mode_t              mode;
        logic [FRAME_W-1:0] frame_ticks;
        logic [BIT_W-1:0]   bit_index;
        logic [7:0]         shift_byte;
        logic               parity_latch;
        logic               armed;
        logic               first_pending;
        logic [WAIT_W-1:0]  wait_ticks;
        res_t               due_results[$];
        int unsigned        mismatch_count;
        int unsigned        beat_count;

        function new();
            etu_reg        = ETU_RESET;
            offset_reg     = OFFSET_RESET;
            timeout_reg    = TIMEOUT_RESET;
            discard_reg    = DISCARD_RESET;
            mode           = MODE_IDLE;
            frame_ticks    = '0;
            bit_index      = '0;
            shift_byte     = '0;
            parity_latch   = 1'b0;
            armed          = 1'b0;
            first_pending  = 1'b0;
            wait_ticks     = '0;
            mismatch_count = 0;
            beat_count     = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
            case (idx)
                CFG_ETU:     etu_reg = value[15:0];
                CFG_OFFSET:  offset_reg = value[7:0];
                CFG_TIMEOUT: timeout_reg = value;
                CFG_DISCARD: discard_reg = value[0];
                default: ;
            endcase
        endfunction

        function res_t step_frame_engine(item_t it);
            res_t        r;
            int unsigned etu;
            int unsigned k;
            logic        edge_tick;
            logic        drop;
            r = '0;
            r.line_out = 1'b1;
            etu = (etu_reg == 0) ? 1 : etu_reg;
            edge_tick = 1'b0;
            if (mode == MODE_IDLE) begin
                if (it.op == OP_SEND) begin
                    mode = MODE_TX;
                    frame_ticks = '0;
                    bit_index = '0;
                    shift_byte = it.tx_byte;
                    parity_latch = ^it.tx_byte;
                end else begin
                    if (it.op == OP_ARM) begin
                        armed = 1'b1;
                        wait_ticks = '0;
                        first_pending = 1'b1;
                    end
                    if (armed) begin
                        if (!it.line_in) begin
                            mode = MODE_RX;
                            frame_ticks = '0;
                            bit_index = '0;
                            shift_byte = '0;
                            parity_latch = 1'b0;
                            r.busy_res = 1'b1;
                            edge_tick = 1'b1;
                        end else begin
                            if (wait_ticks != '1) wait_ticks++;
                            if (timeout_reg != 0 && wait_ticks > timeout_reg) begin
                                r.rx_timeout = 1'b1;
                                armed = 1'b0;
                            end
                        end
                    end
                end
            end

            if (mode == MODE_TX) begin
                r.busy_res = 1'b1;
                if (bit_index == 0) r.line_out = 1'b0;
                else if (bit_index <= LAST_DATA_BIT) r.line_out = shift_byte[bit_index - 1];
                else if (bit_index == PARITY_SLOT) r.line_out = parity_latch;
                frame_ticks++;
                if (frame_ticks == (bit_index + 1) * etu) begin
                    bit_index++;
                    if (bit_index > LAST_TX_BIT) begin
                        mode = MODE_IDLE;
                        bit_index = '0;
                        frame_ticks = '0;
                    end
                end
            end else if (mode == MODE_RX && !edge_tick) begin
                k = (bit_index >= PARITY_SLOT) ? REPORT_ETU : bit_index + 1;
                r.busy_res = 1'b1;
                frame_ticks++;
                if (frame_ticks == offset_reg + k * etu) begin
                    if (bit_index < LAST_DATA_BIT) begin
                        shift_byte = shift_byte | (8'(it.line_in) << bit_index);
                        bit_index++;
                    end else if (bit_index == LAST_DATA_BIT) begin
                        parity_latch = it.line_in;
                        bit_index = PARITY_SLOT;
                    end else begin
                        drop = discard_reg && first_pending && shift_byte == FALSE_CHAR
                               && parity_latch;
                        if (!drop) begin
                            r.rx_valid = 1'b1;
                            r.rx_byte = shift_byte;
                            r.rx_check_bit = parity_latch;
                            r.rx_parity_ok = (parity_latch == ^shift_byte);
                            first_pending = 1'b0;
                        end
                        mode = MODE_IDLE;
                        bit_index = '0;
                        frame_ticks = '0;
                    end
                end
            end
            return r;
        endfunction

        function void note_tick(item_t it);
            due_results.push_back(step_frame_engine(it));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            res_t got;
            res_t want;
            got = beat[$bits(res_t)-1:0];
            beat_count++;
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("beat %0d: result with no tick outstanding, tdata=%h",
                             beat_count, beat);
                return;
            end
            want = due_results.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"beat %0d: line/vld/byte/chk/ok/to/busy ",
                              "want %b %b %h %b %b %b %b got %b %b %h %b %b %b %b"},
                             beat_count, want.line_out, want.rx_valid, want.rx_byte,
                             want.rx_check_bit, want.rx_parity_ok, want.rx_timeout,
                             want.busy_res, got.line_out, got.rx_valid, got.rx_byte,
                             got.rx_check_bit, got.rx_parity_ok, got.rx_timeout,
                             got.busy_res);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    char_frame_checker tracker;
    item_t             tick_q[$];
    int unsigned       cur_etu;
    int unsigned       cur_offset;
    int unsigned       burst_left;
    bit                gaps_on;
    bit                long_hold_req;

    iso7816_char_transceiver_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
    end

    function automatic void push_tick(input logic [1:0] op, input logic [7:0] data,
                                      input logic line);
        item_t it;
        it.op = op;
        it.tx_byte = data;
        it.line_in = line;
        tick_q.push_back(it);
    endfunction

    function automatic void push_high(input int unsigned n);
        repeat (n) push_tick(OP_TICK, 8'($urandom), 1'b1);
    endfunction

    // Character as a card would put it on the line, then enough guard for the report.
    function automatic void push_line_char(input logic [1:0] first_op, input logic [7:0] data,
                                           input logic check);
        push_tick(first_op, 8'($urandom), 1'b0);
        repeat (cur_etu - 1) push_tick(OP_TICK, 8'($urandom), 1'b0);
        for (int i = 0; i < 8; i++) repeat (cur_etu) push_tick(OP_TICK, 8'($urandom), data[i]);
        repeat (cur_etu) push_tick(OP_TICK, 8'($urandom), check);
        push_high(2 * cur_etu + cur_offset + $urandom_range(1, 3));
    endfunction

    // Send one byte; poke also fires a send and an arm inside the frame.
    function automatic void push_send(input logic [7:0] data, input bit poke, input bit noisy);
        push_tick(OP_SEND, data, noisy ? 1'($urandom) : 1'b1);
        for (int i = 1; i < FRAME_ETUS * cur_etu + 2; i++) begin
            if (poke && i == 2) push_tick(OP_SEND, ~data, 1'b1);
            else if (poke && i == 4) push_tick(OP_ARM, 8'($urandom), 1'b1);
            else push_tick(OP_TICK, 8'($urandom), noisy ? 1'($urandom) : 1'b1);
        end
    endfunction

    function automatic void push_broken_char();
        repeat (cur_etu) push_tick(OP_TICK, 8'($urandom), 1'b0);
        repeat ($urandom_range(1, 9 * cur_etu)) push_tick(OP_TICK, 8'($urandom), 1'($urandom));
        push_high(cur_offset + REPORT_ETU * cur_etu);
    endfunction

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.set_reg(idx, value);
    endtask

    task automatic configure(input logic [15:0] etu, input logic [7:0] offset,
                             input logic [31:0] timeout, input logic discard);
        cfg_wr_en <= 1'b1;
        put_reg(CFG_ETU, 32'(etu));
        put_reg(CFG_OFFSET, 32'(offset));
        put_reg(CFG_TIMEOUT, timeout);
        put_reg(CFG_DISCARD, 32'(discard));
        cfg_wr_en <= 1'b0;
        cur_etu = (etu == 0) ? 1 : etu;
        cur_offset = offset;
    endtask

    task automatic pace_sender();
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                burst_left = $urandom_range(1, 30);
            end
            burst_left--;
        end
    endtask

    // Play the queued ticks, keep ticking until the engine is back in idle, then settle.
    task automatic play_ticks();
        item_t it;
        while (tick_q.size() != 0 || tracker.mode != MODE_IDLE) begin
            if (tick_q.size() != 0) begin
                it = tick_q.pop_front();
            end else begin
                it.op = OP_TICK;
                it.tx_byte = 8'($urandom);
                it.line_in = 1'b1;
            end
            pace_sender();
            s_tvalid <= 1'b1;
            s_tdata  <= {7'd0, it.line_in, it.tx_byte};
            s_tuser  <= it.op;
            do @(posedge aclk); while (!s_tready);
            tracker.note_tick(it);
        end
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_phase(input int unsigned n_ticks);
        logic [7:0]  data;
        logic        check;
        int unsigned pick;
        push_tick(OP_ARM, 8'($urandom), 1'b1);
        while (tick_q.size() < n_ticks) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                push_high($urandom_range(0, 3));
                data = 8'($urandom);
                check = ^data;
                if ($urandom_range(0, 9) == 0) begin
                    data = FALSE_CHAR;
                    check = 1'b1;
                end else if ($urandom_range(0, 4) == 0) begin
                    check = ~check;
                end
                push_line_char(($urandom_range(0, 7) == 0) ? OP_ARM : OP_TICK, data, check);
            end else if (pick < 60) begin
                push_tick(OP_ARM, 8'($urandom), 1'($urandom));
            end else if (pick < 72) begin
                push_send(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 6))
                    push_tick(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            end else if (pick < 90) begin
                push_broken_char();
            end else begin
                push_high($urandom_range(1, 40));
            end
        end
        play_ticks();
    endtask

    initial begin : result_sink
        int unsigned style;
        int unsigned style_left;
        int unsigned hold_left;
        style = 0;
        style_left = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 200);
                end
                style_left--;
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (style_left % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [15:0] etu;
        logic [7:0]  offset;
        logic [31:0] timeout;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_TICK;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_ETU;
        cfg_wdata <= '0;
        tracker = new();
        cur_etu = ETU_RESET;
        cur_offset = OFFSET_RESET;
        burst_left = 0;
        gaps_on = 1'b1;
        long_hold_req = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: an unarmed low line, the unused op and an arm with no limit
        push_tick(OP_TICK, 8'($urandom), 1'b1);
        repeat (3) push_tick(OP_TICK, 8'($urandom), 1'b0);
        push_tick(OP_UNUSED, 8'($urandom), 1'b1);
        push_tick(OP_ARM, 8'($urandom), 1'b1);
        push_high(4);
        play_ticks();

        // one-tick ETU: sends, requests during a frame, false first character, bad parity
        configure(16'd1, 8'd0, 32'd0, 1'b1);
        push_send(8'h00, 1'b1, 1'b0);
        push_send(8'hFF, 1'b0, 1'b0);
        push_line_char(OP_ARM, FALSE_CHAR, 1'b1);
        push_line_char(OP_TICK, FALSE_CHAR, 1'b1);
        push_line_char(OP_TICK, 8'h00, 1'b0);
        push_line_char(OP_TICK, FALSE_CHAR, 1'b1);
        push_line_char(OP_TICK, 8'h5A, 1'b1);
        push_tick(OP_SEND, 8'h3C, 1'b0);            // send beats a start edge
        push_high(FRAME_ETUS * cur_etu + 1);
        play_ticks();

        // zero ETU, discard off, short timeout
        configure(16'd0, 8'd0, 32'd3, 1'b0);
        push_line_char(OP_ARM, FALSE_CHAR, 1'b1);
        push_high(8);
        repeat (3) push_tick(OP_TICK, 8'($urandom), 1'b0);
        push_tick(OP_ARM, 8'($urandom), 1'b1);
        push_high(2);
        play_ticks();

        // widest ETU and offset: only waits and timeouts, no frame
        configure(16'hFFFF, 8'hFF, 32'd5, 1'b1);
        push_tick(OP_ARM, 8'($urandom), 1'b1);
        push_high(9);
        repeat (2) push_tick(OP_TICK, 8'($urandom), 1'b0);
        push_tick(OP_ARM, 8'($urandom), 1'b1);
        push_high(2);
        play_ticks();

        // sample points past the character, limit that never trips
        configure(16'd3, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        push_line_char(OP_TICK, 8'($urandom), 1'($urandom));
        push_send(8'($urandom), 1'b0, 1'b1);
        play_ticks();

        for (int ph = 0; ph < 6; ph++) begin
            etu = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
            if ($urandom_range(0, 5) == 0) offset = 8'($urandom_range(0, 255));
            else offset = 8'($urandom_range(0, (etu > 1) ? etu - 1 : 0));
            case ($urandom_range(0, 4))
                0, 1: timeout = 32'd0;
                2, 3: timeout = 32'($urandom_range(1, 40));
                default: timeout = $urandom;
            endcase
            configure(etu, offset, timeout, 1'($urandom));
            gaps_on = (ph % 2 == 0);
            if (ph == 1) long_hold_req = 1'b1;
            random_phase(240);
        end

        if (tracker.mismatch_count == 0 && tracker.due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
